// ----- rtl/scbd_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants, microcode table and helpers of the stereo bit crusher
package scbd_pkg;

  // sample and register widths
  localparam int SAMPLE_W   = 24;
  localparam int PHASE_W    = 23;
  localparam int SCALE_W    = 24;
  localparam int WET_W      = 17;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_RATIO  = 100;

  // multiplier and wide-value widths
  localparam int OP_W   = 26;
  localparam int PROD_W = 2 * OP_W;
  localparam int SAT_W  = PROD_W + 1;
  localparam int QSH    = SAMPLE_W + 7;
  localparam int Q_RSH  = 25 - SAMPLE_W;
  localparam int STEP_W = 5;
  localparam int STEP_LAST = 22;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WET      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WET_ONLY = CFG_IDX_W'(4);

  // fixed-point constants
  localparam logic [PHASE_W-1:0] ONE_Q16  = PHASE_W'(64'd1 << FRAC_BITS);
  localparam logic [PHASE_W-1:0] RATE_MIN = ONE_Q16;
  localparam logic [PHASE_W-1:0] RATE_MAX = PHASE_W'(64'(MAX_RATIO) << FRAC_BITS);
  localparam logic [WET_W-1:0]   WET_ONE  = WET_W'(64'd1 << FRAC_BITS);
  localparam logic [WET_W-1:0]   WET_RST  = WET_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic [PROD_W-1:0] CEIL_BIAS = PROD_W'((64'd1 << QSH) - 64'd1);
  localparam logic [PROD_W-1:0] Q_CLAMP   = PROD_W'(64'd1 << 40);
  localparam logic [PROD_W-1:0] Q_ROUND   = PROD_W'(64'd1 << (Q_RSH - 1));
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(64'sd1);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HAND
  } st_t;

  // microword fields
  typedef enum logic [2:0] {
    A_NONE,
    A_DIFF_PREV,
    A_MAG_HELD,
    A_N_CEIL,
    A_DIFF_DRY
  } a_sel_t;

  typedef enum logic [2:0] {
    B_NONE,
    B_FRAC,
    B_SCALE,
    B_RECIP,
    B_WET
  } b_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_HELD,
    WR_PROC_HELD,
    WR_PROC_Q,
    WR_OUT_PROC,
    WR_OUT_MIX
  } wr_sel_t;

  typedef enum logic [1:0] {
    C_NEVER,
    C_NO_HOLD,
    C_NO_QUANT,
    C_WET_ONLY
  } cond_t;

  typedef struct packed {
    a_sel_t              a_sel;
    b_sel_t              b_sel;
    logic                mul;
    wr_sel_t             wr;
    logic                ch;
    cond_t               cond;
    logic [STEP_W-1:0]   target;
    logic                last;
  } uword_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic   load_cur;
    logic   exec;
    logic   commit;
    uword_t uw;
  } dp_ctrl_t;

  function automatic uword_t mk_uw(input a_sel_t a, input b_sel_t b, input logic m,
                                   input wr_sel_t w, input logic c, input cond_t cd,
                                   input int t, input logic l);
    uword_t u;
    u.a_sel  = a;
    u.b_sel  = b;
    u.mul    = m;
    u.wr     = w;
    u.ch     = c;
    u.cond   = cd;
    u.target = STEP_W'(t);
    u.last   = l;
    return u;
  endfunction

  // microprogram: left channel in steps 0..10, right channel in 11..21
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t u;
    case (step)
      5'd0:  u = mk_uw(A_DIFF_PREV, B_FRAC,  1'b0, WR_NONE,      1'b0, C_NO_HOLD,  3,  1'b0);
      5'd1:  u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b0, C_NEVER,    0,  1'b0);
      5'd2:  u = mk_uw(A_NONE,      B_NONE,  1'b0, WR_HELD,      1'b0, C_NEVER,    0,  1'b0);
      5'd3:  u = mk_uw(A_MAG_HELD,  B_SCALE, 1'b0, WR_PROC_HELD, 1'b0, C_NO_QUANT, 8,  1'b0);
      5'd4:  u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b0, C_NEVER,    0,  1'b0);
      5'd5:  u = mk_uw(A_N_CEIL,    B_RECIP, 1'b0, WR_NONE,      1'b0, C_NEVER,    0,  1'b0);
      5'd6:  u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b0, C_NEVER,    0,  1'b0);
      5'd7:  u = mk_uw(A_NONE,      B_NONE,  1'b0, WR_PROC_Q,    1'b0, C_NEVER,    0,  1'b0);
      5'd8:  u = mk_uw(A_DIFF_DRY,  B_WET,   1'b0, WR_OUT_PROC,  1'b0, C_WET_ONLY, 11, 1'b0);
      5'd9:  u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b0, C_NEVER,    0,  1'b0);
      5'd10: u = mk_uw(A_NONE,      B_NONE,  1'b0, WR_OUT_MIX,   1'b0, C_NEVER,    0,  1'b0);
      5'd11: u = mk_uw(A_DIFF_PREV, B_FRAC,  1'b0, WR_NONE,      1'b1, C_NO_HOLD,  14, 1'b0);
      5'd12: u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b1, C_NEVER,    0,  1'b0);
      5'd13: u = mk_uw(A_NONE,      B_NONE,  1'b0, WR_HELD,      1'b1, C_NEVER,    0,  1'b0);
      5'd14: u = mk_uw(A_MAG_HELD,  B_SCALE, 1'b0, WR_PROC_HELD, 1'b1, C_NO_QUANT, 19, 1'b0);
      5'd15: u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b1, C_NEVER,    0,  1'b0);
      5'd16: u = mk_uw(A_N_CEIL,    B_RECIP, 1'b0, WR_NONE,      1'b1, C_NEVER,    0,  1'b0);
      5'd17: u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b1, C_NEVER,    0,  1'b0);
      5'd18: u = mk_uw(A_NONE,      B_NONE,  1'b0, WR_PROC_Q,    1'b1, C_NEVER,    0,  1'b0);
      5'd19: u = mk_uw(A_DIFF_DRY,  B_WET,   1'b0, WR_OUT_PROC,  1'b1, C_WET_ONLY, 22, 1'b0);
      5'd20: u = mk_uw(A_NONE,      B_NONE,  1'b1, WR_NONE,      1'b1, C_NEVER,    0,  1'b0);
      5'd21: u = mk_uw(A_NONE,      B_NONE,  1'b0, WR_OUT_MIX,   1'b1, C_NEVER,    0,  1'b0);
      default: u = mk_uw(A_NONE,    B_NONE,  1'b0, WR_NONE,      1'b0, C_NEVER,    0,  1'b1);
    endcase
    return u;
  endfunction

  // clamp a wide signed value to the sample range
  function automatic sample_t sat_s(input logic signed [SAT_W-1:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/scbd_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for input and result stereo items
interface scbd_in_if;
  import scbd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface scbd_out_if;
  import scbd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/scbd_datapath.sv -----
`timescale 1ns / 1ps
// shared-multiplier datapath driven by the microword: interpolation, quantizer, mix
module scbd_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scbd_pkg::dp_ctrl_t                  ctrl,
  input  scbd_pkg::sample_t                   cur_left,
  input  scbd_pkg::sample_t                   cur_right,
  input  logic [scbd_pkg::PHASE_W-1:0]        frac,
  input  logic [scbd_pkg::SCALE_W-1:0]        scale,
  input  logic [scbd_pkg::SCALE_W-1:0]        recip,
  input  logic [scbd_pkg::WET_W-1:0]          wet,
  output scbd_pkg::sample_t                   res_left,
  output scbd_pkg::sample_t                   res_right
);
  import scbd_pkg::*;

  sample_t cur_r  [2];
  sample_t prev_r [2];
  sample_t held_r [2];
  sample_t res_r  [2];
  sample_t proc_r;
  logic    neg_r;
  logic signed [OP_W-1:0]   a_r, a_nxt;
  logic signed [OP_W-1:0]   b_r, b_nxt;
  logic signed [PROD_W-1:0] prod_r;

  logic                       ch;
  sample_t                    cur_s, prev_s, held_s;
  logic signed [SAMPLE_W:0]   diff_prev, diff_dry, held_ext;
  logic [SAMPLE_W:0]          mag_held;
  logic [PROD_W-1:0]          ceil_sum, n_full, m_full, q_mag;
  logic signed [PROD_W-1:0]   h_rnd;
  logic signed [SAT_W-1:0]    h_sum, q_pos, q_sgn, mix_sum;
  sample_t                    held_val, q_val, mix_val;

  // channel select
  assign ch     = ctrl.uw.ch;
  assign cur_s  = cur_r[ch];
  assign prev_s = prev_r[ch];
  assign held_s = held_r[ch];

  // operand sources
  assign diff_prev = (SAMPLE_W+1)'(cur_s) - (SAMPLE_W+1)'(prev_s);
  assign diff_dry  = (SAMPLE_W+1)'(proc_r) - (SAMPLE_W+1)'(cur_s);
  assign held_ext  = (SAMPLE_W+1)'(held_s);
  assign mag_held  = held_s[SAMPLE_W-1] ? $unsigned(-held_ext) : $unsigned(held_ext);
  assign ceil_sum  = $unsigned(prod_r) + CEIL_BIAS;
  assign n_full    = ceil_sum >> QSH;

  always_comb begin
    case (ctrl.uw.a_sel)
      A_DIFF_PREV: a_nxt = OP_W'(diff_prev);
      A_MAG_HELD:  a_nxt = OP_W'(mag_held);
      A_N_CEIL:    a_nxt = OP_W'(n_full);
      A_DIFF_DRY:  a_nxt = OP_W'(diff_dry);
      default:     a_nxt = a_r;
    endcase
  end

  always_comb begin
    case (ctrl.uw.b_sel)
      B_FRAC:  b_nxt = OP_W'(frac);
      B_SCALE: b_nxt = OP_W'(scale);
      B_RECIP: b_nxt = OP_W'(recip);
      B_WET:   b_nxt = OP_W'(wet);
      default: b_nxt = b_r;
    endcase
  end

  // interpolated hold value: prev + round(product / 2^16), ties up
  assign h_rnd    = (prod_r + HALF_Q16) >>> FRAC_BITS;
  assign h_sum    = SAT_W'(prev_s) + SAT_W'(h_rnd);
  assign held_val = sat_s(h_sum);

  // quantizer rescale: level times reciprocal, halved with rounding, sign restored
  assign m_full = ($unsigned(prod_r) + Q_ROUND) >> Q_RSH;
  assign q_mag  = (m_full > Q_CLAMP) ? Q_CLAMP : m_full;
  assign q_pos  = $signed(SAT_W'(q_mag));
  assign q_sgn  = neg_r ? -q_pos : q_pos;
  assign q_val  = sat_s(q_sgn);

  // dry/wet mix: dry + wet * (proc - dry) / 2^16, ties up
  assign mix_sum = (SAT_W'(cur_s) <<< FRAC_BITS) + SAT_W'(prod_r) + SAT_W'(HALF_Q16);
  assign mix_val = sat_s(mix_sum >>> FRAC_BITS);

  // history state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r[0] <= '0;
      prev_r[1] <= '0;
      held_r[0] <= '0;
      held_r[1] <= '0;
    end else begin
      if (ctrl.exec && ctrl.uw.wr == WR_HELD) begin
        held_r[ch] <= held_val;
      end
      if (ctrl.commit) begin
        prev_r[0] <= cur_r[0];
        prev_r[1] <= cur_r[1];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load_cur) begin
      cur_r[0] <= cur_left;
      cur_r[1] <= cur_right;
    end
    if (ctrl.exec) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      if (ctrl.uw.mul) begin
        prod_r <= a_r * b_r;
      end
      case (ctrl.uw.wr)
        WR_PROC_HELD: begin
          proc_r <= held_s;
          neg_r  <= held_s[SAMPLE_W-1];
        end
        WR_PROC_Q:   proc_r    <= q_val;
        WR_OUT_PROC: res_r[ch] <= proc_r;
        WR_OUT_MIX:  res_r[ch] <= mix_val;
        default: ;
      endcase
    end
  end

  assign res_left  = res_r[0];
  assign res_right = res_r[1];

endmodule

// ----- rtl/stereo_bit_crusher_decimator_top.sv -----
`timescale 1ns / 1ps
// Stereo bit crusher and sample-rate reducer, microcoded over one shared 26x26 multiplier.
// The microprogram runs 3 to 11 steps per channel, set by hold, quantizer on/off and
// wet-only paths. The sequencer takes a new item only when idle; the output register
// lets the next item in while a result waits. Synchronous active-low reset restores
// register defaults and clears phase and sample history.
module stereo_bit_crusher_decimator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  scbd_in_if.sink                           in_ch,
  scbd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [scbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scbd_pkg::*;

  st_t state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] frac_r;
  logic               hold_r;
  logic [PHASE_W-1:0] rate_r;
  logic [SCALE_W-1:0] scale_r, recip_r;
  logic [WET_W-1:0]   wet_r;
  logic               wet_only_r;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_left_r, out_right_r;

  logic               in_ready_s, accept, exec, commit, jump;
  logic               hold_now;
  logic [PHASE_W-1:0] phase_diff, rate_raw, rate_clamp;
  logic [WET_W-1:0]   wet_raw, wet_clamp;
  uword_t             uw;
  dp_ctrl_t           ctrl;
  sample_t            res_left, res_right;

  // configuration with range clamping
  assign rate_raw   = cfg_data[PHASE_W-1:0];
  assign rate_clamp = (rate_raw < RATE_MIN) ? RATE_MIN :
                      (rate_raw > RATE_MAX) ? RATE_MAX : rate_raw;
  assign wet_raw    = cfg_data[WET_W-1:0];
  assign wet_clamp  = (wet_raw > WET_ONE) ? WET_ONE : wet_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_MIN;
      scale_r    <= '0;
      recip_r    <= '0;
      wet_r      <= WET_RST;
      wet_only_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE:     rate_r     <= rate_clamp;
        CFG_SCALE:    scale_r    <= cfg_data[SCALE_W-1:0];
        CFG_RECIP:    recip_r    <= cfg_data[SCALE_W-1:0];
        CFG_WET:      wet_r      <= wet_clamp;
        CFG_WET_ONLY: wet_only_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // phase accumulator, decided when the item is taken
  assign accept     = in_ch.valid && in_ready_s;
  assign hold_now   = phase_r >= rate_r;
  assign phase_diff = phase_r - rate_r;
  assign phase_nxt  = (hold_now ? phase_diff : phase_r) + ONE_Q16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      hold_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frac_r <= phase_diff;
    end
  end

  // microword fetch and branch condition
  assign uw = ucode(step_r);

  always_comb begin
    case (uw.cond)
      C_NO_HOLD:  jump = !hold_r;
      C_NO_QUANT: jump = (recip_r == '0);
      C_WET_ONLY: jump = wet_only_r;
      default:    jump = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (uw.last) state_nxt = ST_HAND;
      ST_HAND: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_s = 1'b0;
    exec       = 1'b0;
    commit     = 1'b0;
    case (state_r)
      ST_IDLE: in_ready_s = 1'b1;
      ST_RUN:  exec = 1'b1;
      ST_HAND: commit = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // step counter
  always_comb begin
    step_nxt = step_r;
    if (accept) begin
      step_nxt = '0;
    end else if (exec) begin
      step_nxt = jump ? uw.target : step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign ctrl.load_cur = accept;
  assign ctrl.exec     = exec;
  assign ctrl.commit   = commit;
  assign ctrl.uw       = uw;

  scbd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cur_left  (in_ch.left_in),
    .cur_right (in_ch.right_in),
    .frac      (frac_r),
    .scale     (scale_r),
    .recip     (recip_r),
    .wet       (wet_r),
    .res_left  (res_left),
    .res_right (res_right)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end
  end

  assign in_ch.ready      = in_ready_s;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;

`ifndef ASSERT_OFF
  // a taken item starts the microprogram
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_RUN)
    else $error("item taken but sequencer not running");

  // a handed-off result is presented
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("result handed off but not valid");

  // the step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r <= STEP_W'(STEP_LAST))
    else $error("step counter beyond program");

  // clamped registers stay in range
  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    rate_r >= RATE_MIN && rate_r <= RATE_MAX)
    else $error("rate step out of range");

  a_wet_range: assert property (@(posedge clk) disable iff (!rst_n)
    wet_r <= WET_ONE)
    else $error("wet mix out of range");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the stereo bit crusher: directed table, then randomized phases
module testbench;
  import scbd_pkg::*;

  // spare register indexes beyond the map, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = CFG_IDX_W'(7);

  // fixed-point helpers at 24-bit samples
  localparam longint SMP_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam longint SMP_MIN   = -SMP_MAX - 64'sd1;
  localparam longint HALF_LSB  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint LVL_SHIFT = SAMPLE_W + 7;
  localparam longint LVL_CEIL  = (64'sd1 <<< LVL_SHIFT) - 64'sd1;
  localparam longint LVL_CLAMP = 64'sd1 <<< 40;
  localparam int     STALL_LIMIT = 2000;
  localparam int     RANDOM_FRAMES = 600;

  typedef struct packed {
    sample_t l;
    sample_t r;
  } stereo_t;

  typedef enum logic {
    ROW_FRAME,
    ROW_WRITE
  } row_kind_t;

  // directed table row: a frame (a = left, b = right) or a register write (a = data)
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  a;
    logic [SAMPLE_W-1:0]    b;
    logic                   pinned;
    stereo_t                want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  steady;
  int                    mismatches = 0;
  int                    stall_cycles = 0;
  stereo_t               due_pairs[$];

  scbd_in_if  in_ch ();
  scbd_out_if out_ch ();

  stereo_bit_crusher_decimator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // crusher model state and register copy
  logic [PHASE_W-1:0] phase_q16;
  logic [PHASE_W-1:0] rate_q16;
  logic [SCALE_W-1:0] lvl_scale;
  logic [SCALE_W-1:0] lvl_recip;
  logic [WET_W-1:0]   wet_frac;
  logic               wet_alone;
  sample_t            last_l, last_r;
  sample_t            hold_l, hold_r;

  function automatic longint clamp_sample(input longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  // linear interpolation at the leftover phase, ties toward plus infinity
  function automatic longint lerp_hold(input longint prev, input longint cur,
                                       input longint frac);
    longint p;
    p = (cur - prev) * frac;
    return clamp_sample(prev + ((p + HALF_LSB) >>> FRAC_BITS));
  endfunction

  // level count rounded away from zero, then rescaled by the reciprocal
  function automatic longint quantize_level(input longint v);
    longint mag, n, m;
    mag = (v < 0) ? -v : v;
    n = (mag * longint'(lvl_scale) + LVL_CEIL) >>> LVL_SHIFT;
    m = (n * longint'(lvl_recip) + 64'sd1) >>> 1;
    if (m > LVL_CLAMP) m = LVL_CLAMP;
    return clamp_sample((v < 0) ? -m : m);
  endfunction

  // dry/wet crossfade, ties toward plus infinity
  function automatic longint blend_dry(input longint dry, input longint proc);
    longint acc;
    acc = (dry <<< FRAC_BITS) + longint'(wet_frac) * (proc - dry);
    return clamp_sample((acc + HALF_LSB) >>> FRAC_BITS);
  endfunction

  function automatic void reset_crusher();
    rate_q16  = ONE_Q16;
    lvl_scale = '0;
    lvl_recip = '0;
    wet_frac  = WET_RST;
    wet_alone = 1'b0;
    phase_q16 = '0;
    last_l    = '0;
    last_r    = '0;
    hold_l    = '0;
    hold_r    = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    logic [PHASE_W-1:0] rv;
    logic [WET_W-1:0]   wv;
    rv = data[PHASE_W-1:0];
    wv = data[WET_W-1:0];
    case (idx)
      CFG_RATE: begin
        if (rv < RATE_MIN) rv = RATE_MIN;
        if (rv > RATE_MAX) rv = RATE_MAX;
        rate_q16 = rv;
      end
      CFG_SCALE:    lvl_scale = data;
      CFG_RECIP:    lvl_recip = data;
      CFG_WET: begin
        if (wv > WET_ONE) wv = WET_ONE;
        wet_frac = wv;
      end
      CFG_WET_ONLY: wet_alone = data[0];
      default: ;
    endcase
  endfunction

  // one stereo frame through the decimator, quantizer and mixer
  function automatic stereo_t crush_frame(input sample_t l, input sample_t r);
    longint  pl, pr;
    stereo_t res;
    if (phase_q16 >= rate_q16) begin
      phase_q16 = phase_q16 - rate_q16;
      hold_l = sample_t'(lerp_hold(longint'(last_l), longint'(l), longint'(phase_q16)));
      hold_r = sample_t'(lerp_hold(longint'(last_r), longint'(r), longint'(phase_q16)));
    end
    phase_q16 = phase_q16 + ONE_Q16;
    last_l = l;
    last_r = r;
    pl = longint'(hold_l);
    pr = longint'(hold_r);
    if (lvl_recip != '0) begin
      pl = quantize_level(pl);
      pr = quantize_level(pr);
    end
    if (!wet_alone) begin
      pl = blend_dry(longint'(l), pl);
      pr = blend_dry(longint'(r), pr);
    end
    res.l = sample_t'(pl);
    res.r = sample_t'(pr);
    return res;
  endfunction

  // random sample: full range, extremes, near zero or a small step from the last one
  function automatic sample_t pick_sample(input int mode, input sample_t near);
    case (mode)
      0, 1: return sample_t'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      3: return sample_t'(longint'($urandom_range(2000)) - 64'sd1000);
      default:
        return sample_t'(clamp_sample(longint'(near) + longint'($urandom_range(131072))
                                      - 64'sd65536));
    endcase
  endfunction

  // push one item, expectation from the model unless pinned by the table
  task automatic send_frame(input sample_t l, input sample_t r, input logic pinned,
                            input stereo_t want);
    stereo_t got;
    while (!steady && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = crush_frame(l, r);
    due_pairs.push_back(pinned ? want : got);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // stop feeding and wait for every result before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_pairs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // directed table
  row_t script[$] = '{
    // after reset: held value starts at zero, half mix
    '{ROW_FRAME, CFG_RATE, 24'h7FFFFF, 24'h800000, 1'b1, '{24'h400000, 24'hC00000}},
    '{ROW_FRAME, CFG_RATE, 24'h000000, 24'h000000, 1'b1, '{24'h400000, 24'hC00000}},
    '{ROW_FRAME, CFG_RATE, 24'hFFFFFF, 24'h000001, 1'b1, '{24'h000000, 24'h000001}},
    // wet only, rate 1.0 holds the previous frame
    '{ROW_WRITE, CFG_WET_ONLY, 24'hFFFFFF, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'hFFFFFF, 24'h000001, 1'b1, '{24'hFFFFFF, 24'h000001}},
    // spare indexes change nothing
    '{ROW_WRITE, CFG_SPARE_A, 24'hFFFFFF, 24'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPARE_B, 24'hFFFFFF, 24'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPARE_C, 24'h000000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h123456, 24'hEDCBAA, 1'b1, '{24'hFFFFFF, 24'h000001}},
    // rate below 1.0 clamps up
    '{ROW_WRITE, CFG_RATE, 24'h000000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h000000, 24'h7FFFFF, 1'b1, '{24'h123456, 24'hEDCBAA}},
    // rate above the ratio limit clamps down
    '{ROW_WRITE, CFG_RATE, 24'hFFFFFF, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h100000, 24'hF00000, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h200000, 24'hE00000, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h300000, 24'hD00000, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h7FFFFF, 24'h800000, 1'b0, '0},
    // rate lowered mid-hold, held value extrapolates and saturates
    '{ROW_WRITE, CFG_RATE, 24'h010000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h800000, 24'h7FFFFF, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h7FFFFF, 24'h800000, 1'b0, '0},
    // quantizer on with zero scale gives silence
    '{ROW_WRITE, CFG_RECIP, 24'hFFFFFF, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h7FFFFF, 24'h800000, 1'b1, '{24'h000000, 24'h000000}},
    // full scale and reciprocal
    '{ROW_WRITE, CFG_SCALE, 24'hFFFFFF, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h800000, 24'h7FFFFF, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h000001, 24'hFFFFFF, 1'b0, '0},
    // four levels
    '{ROW_WRITE, CFG_SCALE, 24'h000400, 24'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_RECIP, 24'h400000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h3A5A5A, 24'hC5A5A5, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h0AAAAA, 24'hF55556, 1'b0, '0},
    // wet above 1.0 clamps, mixing back on
    '{ROW_WRITE, CFG_WET, 24'h01FFFF, 24'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_WET_ONLY, 24'h000000, 24'h0, 1'b0, '0},
    '{ROW_WRITE, CFG_RECIP, 24'h000000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h654321, 24'h9ABCDF, 1'b0, '0},
    // fully dry passes the input through
    '{ROW_WRITE, CFG_WET, 24'h000000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h123456, 24'hEDCBAA, 1'b1, '{24'h123456, 24'hEDCBAA}},
    // fully wet through the mixer
    '{ROW_WRITE, CFG_WET, 24'h010000, 24'h0, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h7FFFFF, 24'h800000, 1'b0, '0},
    '{ROW_FRAME, CFG_RATE, 24'h800000, 24'h7FFFFF, 1'b0, '0}
  };

  // result sink stalls at random, 8 percent of the time, except in steady phases
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    stereo_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_pairs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: left %h right %h", out_ch.left_out, out_ch.right_out);
        mismatches++;
      end else begin
        want = due_pairs.pop_front();
        if (out_ch.left_out !== want.l || out_ch.right_out !== want.r) begin
          if (mismatches < 10)
            $display("mismatch: left exp %h got %h, right exp %h got %h",
                     want.l, out_ch.left_out, want.r, out_ch.right_out);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int          span;
    int          phase_no;
    int          random_frames;
    int          lv;
    int          qmode;
    logic [23:0] scale_v, recip_v, rate_v, wet_v;
    sample_t     near_l, near_r;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    steady         = 1'b0;
    near_l         = '0;
    near_r         = '0;
    random_frames  = 0;
    phase_no       = 0;
    reset_crusher();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i == 0 || script[i - 1].kind == ROW_FRAME) settle();
        write_reg(script[i].idx, script[i].a);
      end else begin
        cfg_we <= 1'b0;
        send_frame(sample_t'(script[i].a), sample_t'(script[i].b), script[i].pinned,
                   script[i].want);
      end
    end

    // random phases: new settings, then a burst of frames
    while (random_frames < RANDOM_FRAMES) begin
      settle();
      steady <= (phase_no == 3 || phase_no == 4);

      case ($urandom_range(9))
        0: rate_v = 24'($urandom);
        1: rate_v = 24'(RATE_MAX);
        2: rate_v = 24'(RATE_MIN);
        3: rate_v = 24'h000000;
        default: rate_v = 24'($urandom_range(65536, 262144));
      endcase

      // mostly a consistent level count and reciprocal
      lv = $urandom_range(1, 4095);
      scale_v = 24'(lv << 8);
      recip_v = (lv == 1) ? 24'hFFFFFF : 24'((32'h1000000 + lv / 2) / lv);
      qmode = $urandom_range(5);
      if (qmode == 0) begin
        recip_v = 24'h000000;
      end else if (qmode == 1) begin
        scale_v = 24'($urandom);
        recip_v = 24'($urandom);
      end else if (qmode == 2) begin
        scale_v = 24'hFFFFFF;
        recip_v = 24'hFFFFFF;
      end

      case ($urandom_range(5))
        0: wet_v = 24'h000000;
        1: wet_v = 24'(WET_ONE);
        2: wet_v = 24'($urandom_range(65537, 131071));
        default: wet_v = 24'($urandom_range(65536));
      endcase

      write_reg(CFG_RATE, rate_v);
      write_reg(CFG_SCALE, scale_v);
      write_reg(CFG_RECIP, recip_v);
      write_reg(CFG_WET, wet_v);
      write_reg(CFG_WET_ONLY, 24'($urandom));
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'(CFG_SPARE_A + $urandom_range(2)), 24'($urandom));
      cfg_we <= 1'b0;

      span = $urandom_range(20, 80);
      for (int k = 0; k < span; k++) begin
        near_l = pick_sample($urandom_range(9), near_l);
        near_r = pick_sample($urandom_range(9), near_r);
        send_frame(near_l, near_r, 1'b0, '0);
        random_frames++;
      end
      phase_no++;
    end

    // drain and let any stray result show up
    in_ch.valid <= 1'b0;
    while (due_pairs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && due_pairs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
